/* rtl/rhcc_pkg.sv */
// Shared types, constants and palette lookup for the RGB hue color classifier.
`default_nettype none

package rhcc_pkg;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [3:0] color_class;
		logic [8:0] hue_deg;
	} pix_out_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_W     = 17;
	localparam int HUE_W     = 9;

	localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_SAT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORANGE_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YELLOW_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_START  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CYAN_START   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_START   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VIOLET_START = 3'd7;

	localparam logic [6:0] RST_BLACK_LEVEL  = 7'd10;
	localparam logic [6:0] RST_WHITE_SAT    = 7'd10;
	localparam logic [8:0] RST_ORANGE_START = 9'd20;
	localparam logic [8:0] RST_YELLOW_START = 9'd50;
	localparam logic [8:0] RST_GREEN_START  = 9'd90;
	localparam logic [8:0] RST_CYAN_START   = 9'd164;
	localparam logic [8:0] RST_BLUE_START   = 9'd210;
	localparam logic [8:0] RST_VIOLET_START = 9'd287;

	localparam logic [3:0] CLS_BLACK  = 4'd0;
	localparam logic [3:0] CLS_WHITE  = 4'd1;
	localparam logic [3:0] CLS_RED    = 4'd2;
	localparam logic [3:0] CLS_ORANGE = 4'd3;
	localparam logic [3:0] CLS_YELLOW = 4'd4;
	localparam logic [3:0] CLS_GREEN  = 4'd5;
	localparam logic [3:0] CLS_LBLUE  = 4'd6;
	localparam logic [3:0] CLS_BLUE   = 4'd7;
	localparam logic [3:0] CLS_VIOLET = 4'd8;

	function automatic rgb_t palette(input logic [3:0] cls);
		rgb_t c;
		unique case (cls)
			CLS_BLACK:  c = '{8'd0,   8'd0,   8'd0};
			CLS_WHITE:  c = '{8'd255, 8'd255, 8'd255};
			CLS_RED:    c = '{8'd255, 8'd0,   8'd0};
			CLS_ORANGE: c = '{8'd255, 8'd165, 8'd0};
			CLS_YELLOW: c = '{8'd255, 8'd255, 8'd0};
			CLS_GREEN:  c = '{8'd0,   8'd255, 8'd0};
			CLS_LBLUE:  c = '{8'd0,   8'd170, 8'd255};
			CLS_BLUE:   c = '{8'd0,   8'd0,   8'd255};
			CLS_VIOLET: c = '{8'd139, 8'd0,   8'd255};
			default:    c = '{8'd0,   8'd0,   8'd0};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/rgb_hue_color_classifier_top.sv */
// Top level: six-stage pixel pipeline classifying RGB pixels by value, saturation and hue.
//
// Usage: pixels enter on in_valid/in_stall/in_data and leave on
// out_valid/out_stall/out_data; a request moves when valid is high and stall
// is low. Each pixel yields exactly one result, in order.
// One pixel is accepted per cycle while in_stall is low. The stages are
// min/max, numerator and black/white tests, three stages of restoring hue
// division (three quotient bits each), and band classification into the
// output register.
// Each stage advances when its successor is free, so bubbles close up while
// out_stall is high; in_stall rises only when all six stages hold pixels.
// Threshold registers are written through cfg_we/cfg_index/cfg_data and
// must only change while the pipeline is empty.
// Reset clears all stage valid bits and loads the default thresholds.
`default_nettype none

module rgb_hue_color_classifier_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire rhcc_pkg::pix_in_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output rhcc_pkg::pix_out_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [rhcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rhcc_pkg::CFG_W-1:0]    cfg_data
);

	localparam logic [1:0] MAX_RED   = 2'd0;
	localparam logic [1:0] MAX_GREEN = 2'd1;
	localparam logic [1:0] MAX_BLUE  = 2'd2;

	localparam int NW = rhcc_pkg::NUM_W;
	localparam int HW = rhcc_pkg::HUE_W;

	logic [6:0] black_q, white_q;
	logic [8:0] orange_q, yellow_q, green_q, cyan_q, blue_q, violet_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic [7:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	logic [1:0] sel_s1;

	logic [NW-1:0] rem_s2, rem_s3, rem_s4;
	logic [7:0]    d_s2, d_s3, d_s4;
	logic [HW-1:0] q_s3, q_s4, q_s5;
	logic          blk_s2, blk_s3, blk_s4, blk_s5;
	logic          wht_s2, wht_s3, wht_s4, wht_s5;
	logic          gry_s2, gry_s3, gry_s4, gry_s5;

	rhcc_pkg::pix_out_t out_s6;

	logic [7:0]  mx_c, mn_c;
	logic [1:0]  sel_c;
	logic [7:0]  d_c;
	logic signed [17:0] rs_c, gs_c, bs_c, ds_c, n_c;
	logic [15:0] mx100_c, blk255_c, d100_c, wmx_c;
	logic signed [16:0] floor_c;
	logic        blk_c, wht_c;
	logic [NW+2:0] div3_c, div4_c, div5_c;
	logic [HW-1:0] hue_c;
	logic [3:0]  cls_c;
	rhcc_pkg::rgb_t pal_c;

	function automatic logic [NW+2:0] div3(input logic [NW-1:0] rem, input logic [7:0] dv,
			input int top);
		logic [NW-1:0] r;
		logic [NW-1:0] sh;
		logic [2:0]    q;
		r = rem;
		q = '0;
		for (int i = 0; i < 3; i++) begin
			sh = NW'({{(NW-8){1'b0}}, dv} << (top - i));
			if (r >= sh) begin
				r = r - sh;
				q[2-i] = 1'b1;
			end
		end
		return {q, r};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q  <= rhcc_pkg::RST_BLACK_LEVEL;
			white_q  <= rhcc_pkg::RST_WHITE_SAT;
			orange_q <= rhcc_pkg::RST_ORANGE_START;
			yellow_q <= rhcc_pkg::RST_YELLOW_START;
			green_q  <= rhcc_pkg::RST_GREEN_START;
			cyan_q   <= rhcc_pkg::RST_CYAN_START;
			blue_q   <= rhcc_pkg::RST_BLUE_START;
			violet_q <= rhcc_pkg::RST_VIOLET_START;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rhcc_pkg::REG_BLACK_LEVEL:  black_q  <= cfg_data[6:0];
				rhcc_pkg::REG_WHITE_SAT:    white_q  <= cfg_data[6:0];
				rhcc_pkg::REG_ORANGE_START: orange_q <= cfg_data;
				rhcc_pkg::REG_YELLOW_START: yellow_q <= cfg_data;
				rhcc_pkg::REG_GREEN_START:  green_q  <= cfg_data;
				rhcc_pkg::REG_CYAN_START:   cyan_q   <= cfg_data;
				rhcc_pkg::REG_BLUE_START:   blue_q   <= cfg_data;
				rhcc_pkg::REG_VIOLET_START: violet_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy6     = !v_s6 || !out_stall;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_comb begin
		mx_c  = in_data.in_red;
		mn_c  = in_data.in_red;
		sel_c = MAX_RED;
		if (in_data.in_green > mx_c) mx_c = in_data.in_green;
		if (in_data.in_blue > mx_c) mx_c = in_data.in_blue;
		if (in_data.in_green < mn_c) mn_c = in_data.in_green;
		if (in_data.in_blue < mn_c) mn_c = in_data.in_blue;
		priority if (in_data.in_red == mx_c) sel_c = MAX_RED;
		else if (in_data.in_green == mx_c) sel_c = MAX_GREEN;
		else sel_c = MAX_BLUE;
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			r_s1   <= in_data.in_red;
			g_s1   <= in_data.in_green;
			b_s1   <= in_data.in_blue;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sel_s1 <= sel_c;
		end
	end

	always_comb begin
		d_c  = mx_s1 - mn_s1;
		rs_c = $signed({10'b0, r_s1});
		gs_c = $signed({10'b0, g_s1});
		bs_c = $signed({10'b0, b_s1});
		ds_c = $signed({10'b0, d_c});
		unique case (sel_s1)
			MAX_RED: begin
				n_c = 18'sd60 * (gs_c - bs_c);
				if (n_c < 0) n_c = n_c + 18'sd360 * ds_c;
			end
			MAX_GREEN: n_c = 18'sd60 * (bs_c - rs_c) + 18'sd120 * ds_c;
			default:   n_c = 18'sd60 * (rs_c - gs_c) + 18'sd240 * ds_c;
		endcase
		mx100_c  = 16'(mx_s1) * 16'd100;
		blk255_c = 16'(black_q) * 16'd255;
		d100_c   = 16'(d_c) * 16'd100;
		wmx_c    = 16'(white_q) * 16'(mx_s1);
		floor_c  = (17'sd100 - $signed({10'b0, black_q})) * 17'sd255;
		blk_c    = mx100_c < blk255_c;
		wht_c    = (d100_c < wmx_c) && ($signed({1'b0, mx100_c}) > floor_c);
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			rem_s2 <= n_c[NW-1:0];
			d_s2   <= d_c;
			blk_s2 <= blk_c;
			wht_s2 <= wht_c;
			gry_s2 <= d_c == 8'd0;
		end
	end

	assign div3_c = div3(rem_s2, d_s2, 8);
	assign div4_c = div3(rem_s3, d_s3, 5);
	assign div5_c = div3(rem_s4, d_s4, 2);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			rem_s3 <= div3_c[NW-1:0];
			q_s3   <= {div3_c[NW+2:NW], 6'b0};
			d_s3   <= d_s2;
			blk_s3 <= blk_s2;
			wht_s3 <= wht_s2;
			gry_s3 <= gry_s2;
		end
		if (rdy4) begin
			rem_s4 <= div4_c[NW-1:0];
			q_s4   <= {q_s3[8:6], div4_c[NW+2:NW], 3'b0};
			d_s4   <= d_s3;
			blk_s4 <= blk_s3;
			wht_s4 <= wht_s3;
			gry_s4 <= gry_s3;
		end
		if (rdy5) begin
			q_s5   <= {q_s4[8:3], div5_c[NW+2:NW]};
			blk_s5 <= blk_s4;
			wht_s5 <= wht_s4;
			gry_s5 <= gry_s4;
		end
	end

	always_comb begin
		hue_c = (blk_s5 || wht_s5 || gry_s5) ? '0 : q_s5;
		priority if (blk_s5) cls_c = rhcc_pkg::CLS_BLACK;
		else if (wht_s5) cls_c = rhcc_pkg::CLS_WHITE;
		else if (hue_c < orange_q) cls_c = rhcc_pkg::CLS_RED;
		else if (hue_c < yellow_q) cls_c = rhcc_pkg::CLS_ORANGE;
		else if (hue_c < green_q) cls_c = rhcc_pkg::CLS_YELLOW;
		else if (hue_c < cyan_q) cls_c = rhcc_pkg::CLS_GREEN;
		else if (hue_c < blue_q) cls_c = rhcc_pkg::CLS_LBLUE;
		else if (hue_c < violet_q) cls_c = rhcc_pkg::CLS_BLUE;
		else cls_c = rhcc_pkg::CLS_VIOLET;
		pal_c = rhcc_pkg::palette(cls_c);
	end

	always_ff @(posedge clk) begin
		if (rdy6) begin
			out_s6.out_red     <= pal_c.red;
			out_s6.out_green   <= pal_c.green;
			out_s6.out_blue    <= pal_c.blue;
			out_s6.color_class <= cls_c;
			out_s6.hue_deg     <= hue_c;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = out_s6;

endmodule

`default_nettype wire

/* test/rgb_hue_color_classifier_top_tb.sv */
// Self-checking testbench for the RGB hue color classifier: random pixels, thresholds and stalls.
`default_nettype none

module rgb_hue_color_classifier_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PIPE_DEPTH  = 6;

	class hue_class_scoreboard;
		logic [8:0]         thresholds [8];
		rhcc_pkg::pix_out_t expected_pixels [$];
		int                 mismatches;

		function new();
			mismatches = 0;
			thresholds[rhcc_pkg::REG_BLACK_LEVEL]  = {2'b00, rhcc_pkg::RST_BLACK_LEVEL};
			thresholds[rhcc_pkg::REG_WHITE_SAT]    = {2'b00, rhcc_pkg::RST_WHITE_SAT};
			thresholds[rhcc_pkg::REG_ORANGE_START] = rhcc_pkg::RST_ORANGE_START;
			thresholds[rhcc_pkg::REG_YELLOW_START] = rhcc_pkg::RST_YELLOW_START;
			thresholds[rhcc_pkg::REG_GREEN_START]  = rhcc_pkg::RST_GREEN_START;
			thresholds[rhcc_pkg::REG_CYAN_START]   = rhcc_pkg::RST_CYAN_START;
			thresholds[rhcc_pkg::REG_BLUE_START]   = rhcc_pkg::RST_BLUE_START;
			thresholds[rhcc_pkg::REG_VIOLET_START] = rhcc_pkg::RST_VIOLET_START;
		endfunction

		function void write_threshold(logic [2:0] idx, logic [8:0] data);
			if (idx == rhcc_pkg::REG_BLACK_LEVEL || idx == rhcc_pkg::REG_WHITE_SAT)
				thresholds[idx] = {2'b00, data[6:0]};
			else
				thresholds[idx] = data;
		endfunction

		function logic [23:0] palette_rgb(logic [3:0] cls);
			case (cls)
				rhcc_pkg::CLS_WHITE:  return {8'd255, 8'd255, 8'd255};
				rhcc_pkg::CLS_RED:    return {8'd255, 8'd0,   8'd0};
				rhcc_pkg::CLS_ORANGE: return {8'd255, 8'd165, 8'd0};
				rhcc_pkg::CLS_YELLOW: return {8'd255, 8'd255, 8'd0};
				rhcc_pkg::CLS_GREEN:  return {8'd0,   8'd255, 8'd0};
				rhcc_pkg::CLS_LBLUE:  return {8'd0,   8'd170, 8'd255};
				rhcc_pkg::CLS_BLUE:   return {8'd0,   8'd0,   8'd255};
				rhcc_pkg::CLS_VIOLET: return {8'd139, 8'd0,   8'd255};
				default:              return {8'd0,   8'd0,   8'd0};
			endcase
		endfunction

		function rhcc_pkg::pix_out_t classify_pixel(rhcc_pkg::pix_in_t p);
			rhcc_pkg::pix_out_t res;
			int                 r, g, b, mx, mn, d, num, hue, blk, wht;
			logic [3:0]         cls;
			r = int'(p.in_red);
			g = int'(p.in_green);
			b = int'(p.in_blue);
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			blk = int'(thresholds[rhcc_pkg::REG_BLACK_LEVEL]);
			wht = int'(thresholds[rhcc_pkg::REG_WHITE_SAT]);
			hue = 0;
			if (mx * 100 < blk * 255) begin
				cls = rhcc_pkg::CLS_BLACK;
			end else if (d * 100 < wht * mx && mx * 100 > (100 - blk) * 255) begin
				cls = rhcc_pkg::CLS_WHITE;
			end else begin
				if (d != 0) begin
					if (r == mx) begin
						num = 60 * (g - b);
						if (num < 0) num += 360 * d;
					end else if (g == mx) begin
						num = 60 * (b - r) + 120 * d;
					end else begin
						num = 60 * (r - g) + 240 * d;
					end
					hue = num / d;
				end
				if (hue < int'(thresholds[rhcc_pkg::REG_ORANGE_START]))
					cls = rhcc_pkg::CLS_RED;
				else if (hue < int'(thresholds[rhcc_pkg::REG_YELLOW_START]))
					cls = rhcc_pkg::CLS_ORANGE;
				else if (hue < int'(thresholds[rhcc_pkg::REG_GREEN_START]))
					cls = rhcc_pkg::CLS_YELLOW;
				else if (hue < int'(thresholds[rhcc_pkg::REG_CYAN_START]))
					cls = rhcc_pkg::CLS_GREEN;
				else if (hue < int'(thresholds[rhcc_pkg::REG_BLUE_START]))
					cls = rhcc_pkg::CLS_LBLUE;
				else if (hue < int'(thresholds[rhcc_pkg::REG_VIOLET_START]))
					cls = rhcc_pkg::CLS_BLUE;
				else
					cls = rhcc_pkg::CLS_VIOLET;
			end
			{res.out_red, res.out_green, res.out_blue} = palette_rgb(cls);
			res.color_class = cls;
			res.hue_deg = hue[8:0];
			return res;
		endfunction

		function void note_request(rhcc_pkg::pix_in_t p);
			expected_pixels.push_back(classify_pixel(p));
		endfunction

		function void compare_field(string name, logic [8:0] want, logic [8:0] got);
			if (want !== got) begin
				if (mismatches < 40)
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(rhcc_pkg::pix_out_t got);
			rhcc_pkg::pix_out_t want;
			if (expected_pixels.size() == 0) begin
				if (mismatches < 40)
					$display("%0t: result with no request pending: expected none, %s %0d hue %0d",
						$time, "got class", got.color_class, got.hue_deg);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("out_red", 9'(want.out_red), 9'(got.out_red));
			compare_field("out_green", 9'(want.out_green), 9'(got.out_green));
			compare_field("out_blue", 9'(want.out_blue), 9'(got.out_blue));
			compare_field("color_class", 9'(want.color_class), 9'(got.color_class));
			compare_field("hue_deg", want.hue_deg, got.hue_deg);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	rhcc_pkg::pix_in_t  in_data;
	logic               out_valid;
	logic               out_stall;
	rhcc_pkg::pix_out_t out_data;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [8:0]         cfg_data;

	hue_class_scoreboard board;
	bit                  calm;

	rgb_hue_color_classifier_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic rhcc_pkg::pix_in_t rand_pixel();
		rhcc_pkg::pix_in_t p;
		int                base;
		p.in_red   = 8'($urandom);
		p.in_green = 8'($urandom);
		p.in_blue  = 8'($urandom);
		case ($urandom_range(0, 9))
			5: begin
				base = $urandom_range(0, 250);
				p.in_red   = 8'(base + $urandom_range(0, 5));
				p.in_green = 8'(base + $urandom_range(0, 5));
				p.in_blue  = 8'(base + $urandom_range(0, 5));
			end
			6: begin
				p.in_red   = 8'($urandom_range(0, 40));
				p.in_green = 8'($urandom_range(0, 40));
				p.in_blue  = 8'($urandom_range(0, 40));
			end
			7: p.in_green = p.in_red;
			8: begin
				p.in_red  = 8'd255;
				p.in_blue = 8'd0;
			end
			9: begin
				p.in_red   = 8'($urandom_range(200, 255));
				p.in_green = 8'($urandom_range(200, 255));
				p.in_blue  = 8'($urandom_range(200, 255));
			end
			default: ;
		endcase
		case ($urandom_range(0, 2))
			1: p = '{p.in_green, p.in_blue, p.in_red};
			2: p = '{p.in_blue, p.in_red, p.in_green};
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_pixel(rhcc_pkg::pix_in_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = p;
		do @(posedge clk); while (in_stall);
		board.note_request(p);
		@(negedge clk);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
			send_pixel(rand_pixel());
		end
		in_valid = 1'b0;
		calm = 1'b0;
	endtask

	task automatic write_threshold(logic [2:0] idx, logic [8:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		board.write_threshold(idx, data);
	endtask

	task automatic load_thresholds(logic [8:0] blk, logic [8:0] wht, logic [8:0] orange,
			logic [8:0] yellow, logic [8:0] green, logic [8:0] cyan, logic [8:0] blue,
			logic [8:0] violet);
		write_threshold(rhcc_pkg::REG_BLACK_LEVEL, blk);
		write_threshold(rhcc_pkg::REG_WHITE_SAT, wht);
		write_threshold(rhcc_pkg::REG_ORANGE_START, orange);
		write_threshold(rhcc_pkg::REG_YELLOW_START, yellow);
		write_threshold(rhcc_pkg::REG_GREEN_START, green);
		write_threshold(rhcc_pkg::REG_CYAN_START, cyan);
		write_threshold(rhcc_pkg::REG_BLUE_START, blue);
		write_threshold(rhcc_pkg::REG_VIOLET_START, violet);
	endtask

	task automatic load_random_thresholds();
		int deg [6];
		int blk, wht;
		blk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 40);
		wht = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 60);
		if ($urandom_range(0, 3) == 0) begin
			foreach (deg[i]) deg[i] = $urandom_range(0, 511);
		end else begin
			foreach (deg[i]) deg[i] = $urandom_range(0, 360);
			deg.sort();
		end
		load_thresholds(9'(blk), 9'(wht), 9'(deg[0]), 9'(deg[1]), 9'(deg[2]), 9'(deg[3]),
			9'(deg[4]), 9'(deg[5]));
	endtask

	task automatic wait_drained();
		while (board.pending() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_data);
	end

	initial begin
		int hold, r;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_stall = 1'b1;
			end else if (calm) begin
				out_stall = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_stall = 1'b0;
				end else begin
					out_stall = 1'b1;
					hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[rgb_hue_color_classifier_top] ERROR");
		$finish;
	end

	initial begin
		rhcc_pkg::pix_in_t directed_pixels [$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = rhcc_pkg::REG_BLACK_LEVEL;
		cfg_data = '0;
		calm = 1'b0;
		board = new();
		directed_pixels = '{
			'{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0,   8'd0},
			'{8'd255, 8'd0,   8'd1},   '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd0},
			'{8'd0,   8'd255, 8'd255}, '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd255},
			'{8'd25,  8'd0,   8'd0},   '{8'd26,  8'd26,  8'd26},  '{8'd229, 8'd229, 8'd229},
			'{8'd230, 8'd230, 8'd210}, '{8'd255, 8'd230, 8'd230}, '{8'd255, 8'd84,  8'd0},
			'{8'd255, 8'd85,  8'd0},   '{8'd255, 8'd212, 8'd0},   '{8'd255, 8'd213, 8'd0},
			'{8'd0,   8'd255, 8'd1},   '{8'd128, 8'd255, 8'd0},   '{8'd127, 8'd255, 8'd0},
			'{8'd255, 8'd128, 8'd128}, '{8'd0,   8'd0,   8'd1}
		};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
		in_valid = 1'b0;
		run_random(150);

		wait_drained();
		load_thresholds(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
		run_random(60);

		wait_drained();
		load_thresholds(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
		run_random(40);

		wait_drained();
		load_thresholds(9'd100, 9'd100, 9'd360, 9'd360, 9'd360, 9'd360, 9'd360, 9'd360);
		run_random(40);

		wait_drained();
		load_thresholds(9'd0, 9'd0, 9'd300, 9'd100, 9'd200, 9'd50, 9'd250, 9'd359);
		run_random(120);

		repeat (8) begin
			wait_drained();
			load_random_thresholds();
			run_random(190);
		end

		while (board.pending() != 0) @(negedge clk);
		repeat (PIPE_DEPTH * 4) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[rgb_hue_color_classifier_top] OK");
		else
			$display("[rgb_hue_color_classifier_top] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
rtl/rhcc_pkg.sv
rtl/rgb_hue_color_classifier_top.sv
test/rgb_hue_color_classifier_top_tb.sv
